// File: design/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/fimr_pkg.sv
package fimr_pkg;

    // Item kinds on the input side.
    typedef enum logic [1:0] {
        OP_MASK     = 2'd0,
        OP_UNMASK   = 2'd1,
        OP_RESOLVE  = 2'd2,
        OP_SET_TYPE = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    localparam int unsigned LINE_W          = 8;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned GPIO_FIRST_LINE = 96;
    localparam int unsigned LINE_COUNT      = 192;
    localparam int unsigned GPIO_WORDS      = 3;
    localparam int unsigned GPIO_MARKS      = 96;
    localparam int unsigned HIGH_BASE       = 32;
    localparam int unsigned ERROR_BASE      = 64;
    localparam int unsigned GPIO_SUM_FIRST  = 4;
    localparam int unsigned GPIO_SUM_LAST   = 15;
    localparam int unsigned GPIO_GROUP      = 8;

    localparam int unsigned IN_DATA_W  = 112;
    localparam int unsigned OUT_DATA_W = 16;

endpackage

// File: design/fast_interrupt_mask_and_resolve.sv
// Throughput: one item per cycle while m_axis_tready does not stall the result
// register; each item passes an input register, one level of mask update or
// priority-encode logic, and the result register, which offers it on the master side.
// Reset (rst_n, asynchronous, active low) masks every line, clears the GPIO mask,
// polarity and change-level state, and empties both pipeline registers.
module fast_interrupt_mask_and_resolve (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata fields from bit 0: line[7:0], change_level[8], cause_low[40:9],
    // cause_high[72:41], cause_error[104:73], zero fill [111:105].
    input  logic [fimr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser fields from bit 0: op[1:0].
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata fields from bit 0: status[1:0], found[2], pending_line[10:3],
    // zero fill [15:11].
    output logic [fimr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fimr_pkg::*;

    // Index of the lowest set bit of a word; only meaningful when the word is nonzero.
    function automatic logic [4:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [4:0] b;
        b = 5'd0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

    // Input stage.
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [LINE_W-1:0]   in_line_reg;
    logic                in_cl_reg;
    logic [WORD_W-1:0]   in_cause_low_reg;
    logic [WORD_W-1:0]   in_cause_high_reg;
    logic [WORD_W-1:0]   in_cause_error_reg;

    // Result stage.
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_found_reg;
    logic [LINE_W-1:0]   out_line_reg;
    status_t             out_status_next;
    logic                out_found_next;
    logic [LINE_W-1:0]   out_line_next;

    // Mask state.
    logic [WORD_W-1:0]   low_mask_reg, low_mask_next;
    logic [WORD_W-1:0]   high_mask_reg, high_mask_next;
    logic [WORD_W-1:0]   error_mask_reg, error_mask_next;
    logic [WORD_W-1:0]   gpio_mask_reg [GPIO_WORDS];
    logic [WORD_W-1:0]   gpio_mask_next [GPIO_WORDS];
    logic [WORD_W-1:0]   gpio_pol_reg [GPIO_WORDS];
    logic [WORD_W-1:0]   gpio_pol_next [GPIO_WORDS];
    logic [GPIO_MARKS-1:0] gpio_cl_reg, gpio_cl_next;

    logic advance;
    logic in_take;

    // The result register moves when it is empty or being drained; the input
    // register refills whenever its item moves on.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg          <= op_t'(s_axis_tuser);
            in_line_reg        <= s_axis_tdata[7:0];
            in_cl_reg          <= s_axis_tdata[8];
            in_cause_low_reg   <= s_axis_tdata[40:9];
            in_cause_high_reg  <= s_axis_tdata[72:41];
            in_cause_error_reg <= s_axis_tdata[104:73];
        end
    end

    // Line decode shared by mask, unmask and set-type items.
    logic                in_range;
    logic [LINE_W-1:0]   gpio_off;
    logic                gpio_line;
    logic                gpio_stored;
    logic [1:0]          gpio_idx;
    logic [WORD_W-1:0]   line_bit;

    assign in_range    = in_line_reg < LINE_W'(LINE_COUNT);
    assign gpio_line   = in_line_reg >= LINE_W'(GPIO_FIRST_LINE);
    assign gpio_off    = in_line_reg - LINE_W'(GPIO_FIRST_LINE);
    assign gpio_stored = gpio_line && (gpio_off < LINE_W'(GPIO_MARKS));
    assign gpio_idx    = gpio_off[6:5];
    assign line_bit    = WORD_W'(1) << in_line_reg[4:0];

    // Resolve: masked cause words and their lowest pending bits.
    logic [WORD_W-1:0]   low_hits, high_hits, error_hits;
    logic [4:0]          low_b, high_b, error_b;
    logic                high_is_gpio;

    assign low_hits     = in_cause_low_reg & low_mask_reg;
    assign high_hits    = in_cause_high_reg & high_mask_reg;
    assign error_hits   = in_cause_error_reg & error_mask_reg;
    assign low_b        = lowest_bit(low_hits);
    assign high_b       = lowest_bit(high_hits);
    assign error_b      = lowest_bit(error_hits);
    assign high_is_gpio = (high_b >= 5'(GPIO_SUM_FIRST)) && (high_b <= 5'(GPIO_SUM_LAST));

    always_comb
    begin
        low_mask_next   = low_mask_reg;
        high_mask_next  = high_mask_reg;
        error_mask_next = error_mask_reg;
        gpio_mask_next  = gpio_mask_reg;
        gpio_pol_next   = gpio_pol_reg;
        gpio_cl_next    = gpio_cl_reg;
        out_status_next = ST_OK;
        out_found_next  = 1'b0;
        out_line_next   = '0;

        unique case (in_op_reg)
            OP_MASK, OP_UNMASK:
            begin
                if (!in_range)
                begin
                    out_status_next = ST_RANGE;
                end
                else if (in_line_reg < LINE_W'(HIGH_BASE))
                begin
                    low_mask_next = (in_op_reg == OP_UNMASK) ? (low_mask_reg | line_bit)
                                                             : (low_mask_reg & ~line_bit);
                end
                else if (in_line_reg < LINE_W'(ERROR_BASE))
                begin
                    high_mask_next = (in_op_reg == OP_UNMASK) ? (high_mask_reg | line_bit)
                                                              : (high_mask_reg & ~line_bit);
                end
                else if (!gpio_line)
                begin
                    error_mask_next = (in_op_reg == OP_UNMASK) ? (error_mask_reg | line_bit)
                                                               : (error_mask_reg & ~line_bit);
                end
                else if (gpio_stored)
                begin
                    if (in_op_reg == OP_UNMASK)
                    begin
                        gpio_mask_next[gpio_idx] = gpio_mask_reg[gpio_idx] | line_bit;
                        // Unmasking a change-level line flips its polarity so the
                        // next edge in the opposite direction is caught.
                        if (gpio_cl_reg[gpio_off[6:0]])
                        begin
                            gpio_pol_next[gpio_idx] = gpio_pol_reg[gpio_idx] ^ line_bit;
                        end
                    end
                    else
                    begin
                        gpio_mask_next[gpio_idx] = gpio_mask_reg[gpio_idx] & ~line_bit;
                    end
                end
            end
            OP_SET_TYPE:
            begin
                if (!in_range)
                begin
                    out_status_next = ST_RANGE;
                end
                else if (gpio_stored)
                begin
                    gpio_cl_next[gpio_off[6:0]] = in_cl_reg;
                end
            end
            OP_RESOLVE:
            begin
                // Low word first, then the high word when the low summary bit is
                // set, then the error word.
                if (|low_hits)
                begin
                    out_found_next = 1'b1;
                    out_line_next  = LINE_W'(low_b);
                end
                else if (in_cause_low_reg[0] && (|high_hits))
                begin
                    out_found_next = 1'b1;
                    if (high_is_gpio)
                    begin
                        out_line_next = LINE_W'(GPIO_FIRST_LINE)
                            + ((LINE_W'(high_b) - LINE_W'(GPIO_SUM_FIRST)) << 3);
                    end
                    else
                    begin
                        out_line_next = LINE_W'(high_b) + LINE_W'(HIGH_BASE);
                    end
                end
                else if (|error_hits)
                begin
                    out_found_next = 1'b1;
                    out_line_next  = LINE_W'(error_b) + LINE_W'(ERROR_BASE);
                end
                else
                begin
                    out_status_next = ST_NONE;
                end
            end
            default:
            begin
                out_status_next = ST_OK;
            end
        endcase
    end

    logic do_step;
    assign do_step = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_mask_reg   <= '0;
            high_mask_reg  <= '0;
            error_mask_reg <= '0;
            gpio_cl_reg    <= '0;
            for (int i = 0; i < GPIO_WORDS; i++)
            begin
                gpio_mask_reg[i] <= '0;
                gpio_pol_reg[i]  <= '0;
            end
        end
        else if (do_step)
        begin
            low_mask_reg   <= low_mask_next;
            high_mask_reg  <= high_mask_next;
            error_mask_reg <= error_mask_next;
            gpio_cl_reg    <= gpio_cl_next;
            gpio_mask_reg  <= gpio_mask_next;
            gpio_pol_reg   <= gpio_pol_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_line_reg   <= out_line_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_line_reg, out_found_reg, out_status_reg};

endmodule

// File: design/fimr_checker.sv
`include "assert_macros.svh"

module fimr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [fimr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input logic [1:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fimr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fimr_pkg::*;

    logic       found;
    logic [1:0] status;
    logic [7:0] pline;

    assign found  = m_axis_tdata[2];
    assign status = m_axis_tdata[1:0];
    assign pline  = m_axis_tdata[10:3];

    // A found line always reports the ok status and lies among the lines.
    `ASSERT_SAME(a_found_ok, clk, rst_n, m_axis_tvalid && found,
        (status == ST_OK) && (pline < 8'(LINE_COUNT)))
    // Without a found line the line field reads zero and status is a real code.
    `ASSERT_SAME(a_not_found, clk, rst_n, m_axis_tvalid && !found,
        (pline == 8'd0) && (status != 2'd3))
    // A stalled result stays put.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    // After an accepted item the block is either ready for another item or offers a result.
    `ASSERT_NEXT(a_flow, clk, rst_n, s_axis_tvalid && s_axis_tready,
        s_axis_tready || m_axis_tvalid)

endmodule

bind fast_interrupt_mask_and_resolve fimr_checker u_fimr_checker (.*);
